>>> sv/pscf_pkg.sv
package pscf_pkg;

    localparam int OUT_OFFSET_BITS = 24;
    localparam int SIZE_BITS = 17;

    localparam logic [7:0] STREAM_ID = 8'hBD;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] ONE_BYTE = 8'h01;
    localparam logic [SIZE_BITS-1:0] HEADER_BYTES = 17'd6;
    localparam logic [OUT_OFFSET_BITS-1:0] OUT_OFFSET_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pscf_in_t;

    typedef struct packed {
        logic                       found;
        logic [OUT_OFFSET_BITS-1:0] pes_offset;
        logic [SIZE_BITS-1:0]       pes_size;
        logic                       search_over;
    } pscf_out_t;

endpackage

>>> sv/pscf_hunt.sv
module pscf_hunt #(
    parameter int OFFSET_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_en,
    input  pscf_pkg::pscf_in_t item,
    output logic               emit,
    output pscf_pkg::pscf_out_t result
);

    typedef enum logic [2:0] {
        PH_ZERO0,
        PH_ZERO1,
        PH_ONE,
        PH_STREAM,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [15:0]            length_reg, length_next;
    logic [15:0]            remaining_reg, remaining_next;
    logic                   stopped_reg, stopped_next;

    logic [15:0] remaining_dec;
    logic [15:0] length_full;
    logic        found;
    logic        emit_hit;
    logic        offset_sat;

    assign remaining_dec = remaining_reg - 16'd1;
    assign length_full   = {length_reg[15:8], item.data_byte};
    assign offset_sat    = (OFFSET_BITS > pscf_pkg::OUT_OFFSET_BITS)
                        && ((start_reg >> pscf_pkg::OUT_OFFSET_BITS) != '0);

    always_comb begin
        phase_next     = phase_reg;
        start_next     = start_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        stopped_next   = stopped_reg;
        found          = 1'b0;
        emit_hit       = 1'b0;

        if (!stopped_reg) begin
            case (phase_reg)
                PH_ZERO0: begin
                    if (item.data_byte == pscf_pkg::ZERO_BYTE) begin
                        start_next = position_reg;
                        phase_next = PH_ZERO1;
                    end
                end
                PH_ZERO1: begin
                    phase_next = (item.data_byte == pscf_pkg::ZERO_BYTE) ? PH_ONE : PH_ZERO0;
                end
                PH_ONE: begin
                    phase_next = (item.data_byte == pscf_pkg::ONE_BYTE) ? PH_STREAM : PH_ZERO0;
                end
                PH_STREAM: begin
                    if (item.data_byte == pscf_pkg::STREAM_ID) begin
                        phase_next = PH_LEN_HI;
                    end else if (item.data_byte == pscf_pkg::ZERO_BYTE) begin
                        start_next = position_reg;
                        phase_next = PH_ZERO1;
                    end else begin
                        phase_next = PH_ZERO0;
                    end
                end
                PH_LEN_HI: begin
                    length_next = {item.data_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = length_full;
                    if (length_full == 16'd0) begin
                        stopped_next = 1'b1;
                        emit_hit     = 1'b1;
                        phase_next   = PH_ZERO0;
                    end else begin
                        remaining_next = length_full;
                        phase_next     = PH_BODY;
                    end
                end
                PH_BODY: begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == 16'd0) begin
                        found      = 1'b1;
                        emit_hit   = 1'b1;
                        phase_next = PH_ZERO0;
                    end
                end
                default: begin
                    phase_next = PH_ZERO0;
                end
            endcase
        end

        position_next = (position_reg != '1) ? position_reg + 1'b1 : position_reg;

        emit = emit_hit || item.last_byte;

        result.found       = found;
        result.pes_offset  = !found ? '0
                           : offset_sat ? pscf_pkg::OUT_OFFSET_MAX
                           : pscf_pkg::OUT_OFFSET_BITS'(start_reg);
        result.pes_size    = found ? pscf_pkg::HEADER_BYTES + pscf_pkg::SIZE_BITS'(length_reg)
                                   : '0;
        result.search_over = stopped_next || item.last_byte;

        // buffer end returns everything to reset
        if (item.last_byte) begin
            phase_next     = PH_ZERO0;
            position_next  = '0;
            start_next     = '0;
            length_next    = '0;
            remaining_next = '0;
            stopped_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ZERO0;
            position_reg  <= '0;
            start_reg     <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            stopped_reg   <= 1'b0;
        end else if (item_en) begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            start_reg     <= start_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

>>> sv/pes_start_code_finder.sv
// pes_start_code_finder: scans a byte stream for private-stream-1 PES packets
// (start code 00 00 01 BD, 16-bit length, body) and reports each complete one.
// input channel s_valid/s_ready/s_data: one buffer byte per transfer, with
// last_byte set on the final byte of the buffer.
// result channel m_valid/m_ready/m_data: found, pes_offset, pes_size and
// search_over. A result is sent when a PES completes, when a zero length is
// read, and for every byte marked last; other bytes give no result.
// throughput: one byte per clock while m_ready is high, set by the single
// pass through the hunt logic between the input and result registers.
// path: input register, hunt logic, then the result register behind m_valid.
// reset (aresetn low, synchronous) clears the hunt state, the byte counter
// and both valid flags; after a last byte the state also returns to reset.
// when the receiver stalls, the result register holds, the input register
// fills, and s_ready drops until the result is taken.
module pes_start_code_finder #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pscf_pkg::pscf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pscf_pkg::pscf_out_t m_data
);

    logic                in_valid_reg;
    pscf_pkg::pscf_in_t  in_data_reg;
    logic                out_valid_reg, out_valid_next;
    pscf_pkg::pscf_out_t out_data_reg;

    logic                proc;
    logic                emit;
    pscf_pkg::pscf_out_t result;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    pscf_hunt #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_hunt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (proc),
        .item    (in_data_reg),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        if (proc && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc && emit) begin
            out_data_reg <= result;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.pes_size > pscf_pkg::HEADER_BYTES)
        else $error("found result with too small a size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.pes_size == '0 && m_data.pes_offset == '0)
        else $error("empty result carries offset or size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.search_over |-> m_data.found)
        else $error("result with neither found nor search_over");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the result side is free");

endmodule
